>>> hw/rtl/urr_pkg.sv
// shared types and constants for the uniform range reducer
package urr_pkg;

	localparam int DATA_W = 64;
	localparam int IDX_W  = 2;
	// step counter for the rejection threshold remainder
	localparam int CNT_W  = $clog2(DATA_W + 1);

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_LOW  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HIGH = 2'd1;
	localparam logic [IDX_W-1:0] REG_MODE = 2'd2;

	// one item moving down the divider chain
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] draw;
		logic [DATA_W-1:0] rem;
	} stage_t;

	// derived range settings shared by the chain and the output stage
	typedef struct packed {
		logic [DATA_W-1:0] low;
		logic [DATA_W-1:0] bound;
		logic [DATA_W-1:0] reject;
		logic              inverted;
		logic              full;
	} cfg_t;

endpackage

>>> hw/rtl/urr_cfg.sv
// configuration registers and derived range settings
module urr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [urr_pkg::IDX_W-1:0]         cfg_index,
	input  logic [urr_pkg::DATA_W-1:0]        cfg_data,
	output urr_pkg::cfg_t                     cfg,
	output logic                              rej_busy
);

	logic [urr_pkg::DATA_W-1:0] low_q;
	logic [urr_pkg::DATA_W-1:0] high_q;
	logic                       mode_q;
	urr_pkg::cfg_t              cfg_q;
	logic [urr_pkg::DATA_W-1:0] rej_div_q;
	logic [urr_pkg::CNT_W-1:0]  rej_cnt_q;
	logic                       rej_busy_q;

	logic                       wr;
	logic [urr_pkg::DATA_W-1:0] low_nxt;
	logic [urr_pkg::DATA_W-1:0] high_nxt;
	logic                       mode_nxt;
	logic [urr_pkg::DATA_W-1:0] sign_flip;
	logic                       inv_nxt;
	logic [urr_pkg::DATA_W-1:0] span_nxt;
	logic [urr_pkg::DATA_W-1:0] bound_nxt;
	logic [urr_pkg::DATA_W:0]   rej_trial;
	logic [urr_pkg::DATA_W-1:0] rej_step;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid;

	// register values as they stand after this transfer
	always_comb begin
		low_nxt  = low_q;
		high_nxt = high_q;
		mode_nxt = mode_q;
		if (wr) begin
			case (cfg_index)
				urr_pkg::REG_LOW:  low_nxt  = cfg_data;
				urr_pkg::REG_HIGH: high_nxt = cfg_data;
				urr_pkg::REG_MODE: mode_nxt = cfg_data[0];
				default: ;
			endcase
		end
	end

	// signed order by flipping sign bits, span and bound as separate adds
	assign sign_flip = {mode_nxt, {(urr_pkg::DATA_W-1){1'b0}}};
	assign inv_nxt   = (low_nxt ^ sign_flip) > (high_nxt ^ sign_flip);
	assign span_nxt  = high_nxt + ~low_nxt + urr_pkg::DATA_W'(1);
	assign bound_nxt = high_nxt + ~low_nxt + urr_pkg::DATA_W'(2);

	// threshold 2^64 mod bound: restoring remainder of (2^64 - bound), one bit per cycle
	assign rej_trial = {cfg_q.reject, rej_div_q[urr_pkg::DATA_W-1]};
	assign rej_step  = (rej_trial >= {1'b0, cfg_q.bound})
	                   ? urr_pkg::DATA_W'(rej_trial - {1'b0, cfg_q.bound})
	                   : rej_trial[urr_pkg::DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q          <= '0;
			high_q         <= '1;
			mode_q         <= 1'b0;
			cfg_q.low      <= '0;
			cfg_q.bound    <= '0;
			cfg_q.reject   <= '0;
			cfg_q.inverted <= 1'b0;
			cfg_q.full     <= 1'b1;
			rej_div_q      <= '0;
			rej_cnt_q      <= '0;
			rej_busy_q     <= 1'b0;
		end else if (wr) begin
			low_q          <= low_nxt;
			high_q         <= high_nxt;
			mode_q         <= mode_nxt;
			cfg_q.low      <= low_nxt;
			cfg_q.bound    <= bound_nxt;
			cfg_q.reject   <= '0;
			cfg_q.inverted <= inv_nxt;
			cfg_q.full     <= (bound_nxt == '0);
			rej_div_q      <= ~span_nxt;
			rej_cnt_q      <= urr_pkg::CNT_W'(urr_pkg::DATA_W);
			rej_busy_q     <= 1'b1;
		end else if (rej_busy_q) begin
			cfg_q.reject   <= rej_step;
			rej_div_q      <= {rej_div_q[urr_pkg::DATA_W-2:0], 1'b0};
			rej_cnt_q      <= rej_cnt_q - urr_pkg::CNT_W'(1);
			rej_busy_q     <= (rej_cnt_q != urr_pkg::CNT_W'(1));
		end
	end

	assign cfg      = cfg_q;
	assign rej_busy = rej_busy_q;

endmodule

>>> hw/rtl/urr_div_cell.sv
// one restoring division step: brings in one draw bit and reduces by the bound
module urr_div_cell #(
	parameter int BIT = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [urr_pkg::DATA_W-1:0] bound,
	input  urr_pkg::stage_t            stage_in,
	output urr_pkg::stage_t            stage_out
);

	logic [urr_pkg::DATA_W:0]   trial;
	logic                       ge;
	logic [urr_pkg::DATA_W-1:0] rem_nxt;
	logic                       valid_q;
	logic [urr_pkg::DATA_W-1:0] draw_q;
	logic [urr_pkg::DATA_W-1:0] rem_q;

	// shift in the next dividend bit and subtract when it fits
	assign trial   = {stage_in.rem, stage_in.draw[BIT]};
	assign ge      = trial >= {1'b0, bound};
	assign rem_nxt = ge ? urr_pkg::DATA_W'(trial - {1'b0, bound})
	                    : trial[urr_pkg::DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= stage_in.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		draw_q <= stage_in.draw;
		rem_q  <= rem_nxt;
	end

	assign stage_out.valid = valid_q;
	assign stage_out.draw  = draw_q;
	assign stage_out.rem   = rem_q;

endmodule

>>> hw/rtl/urr_out.sv
// final stage: rejection test, offset add and result register
module urr_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  urr_pkg::cfg_t              cfg,
	input  urr_pkg::stage_t            stage_in,
	output logic                       result_valid,
	output logic [urr_pkg::DATA_W-1:0] ranged_value,
	output logic                       range_error
);

	logic                       keep;
	logic                       valid_q;
	logic [urr_pkg::DATA_W-1:0] value_q;
	logic                       error_q;

	// draws below 2^64 mod bound are dropped
	assign keep = stage_in.draw >= cfg.reject;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= stage_in.valid & (cfg.inverted | cfg.full | keep);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cfg.inverted) begin
			value_q <= '0;
			error_q <= 1'b1;
		end else if (cfg.full) begin
			value_q <= stage_in.draw;
			error_q <= 1'b0;
		end else begin
			value_q <= cfg.low + stage_in.rem;
			error_q <= 1'b0;
		end
	end

	assign result_valid = valid_q;
	assign ranged_value = value_q;
	assign range_error  = error_q;

endmodule

>>> hw/rtl/uniform_range_reducer.sv
// top level of the uniform range reducer
// each start goes through 64 division cells and the output register to its result strobe
// throughput: one draw per cycle when busy is low; busy is high after a register write
// while the rejection threshold is rebuilt one bit per cycle
// a rejected draw gives no strobe; the receiver cannot stall, results show for one cycle
// reset: asynchronous, clears the pipeline valid bits and loads the full unsigned range
module uniform_range_reducer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [urr_pkg::DATA_W-1:0]        raw_draw,
	output logic                              result_valid,
	output logic [urr_pkg::DATA_W-1:0]        ranged_value,
	output logic                              range_error,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [urr_pkg::IDX_W-1:0]         cfg_index,
	input  logic [urr_pkg::DATA_W-1:0]        cfg_data
);

	urr_pkg::cfg_t   cfg;
	urr_pkg::stage_t chain [0:urr_pkg::DATA_W];

	urr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.rej_busy  (busy)
	);

	// head of the chain: draw enters with an empty remainder
	assign chain[0].valid = start & ~busy;
	assign chain[0].draw  = raw_draw;
	assign chain[0].rem   = '0;

	// division cells, most significant draw bit first
	for (genvar i = 0; i < urr_pkg::DATA_W; i++) begin : g_cell
		urr_div_cell #(
			.BIT (urr_pkg::DATA_W - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bound     (cfg.bound),
			.stage_in  (chain[i]),
			.stage_out (chain[i+1])
		);
	end

	urr_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.stage_in     (chain[urr_pkg::DATA_W]),
		.result_valid (result_valid),
		.ranged_value (ranged_value),
		.range_error  (range_error)
	);

endmodule
